[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`endif

[rtl/imhdk_pkg.sv]
// Types and constants of the indexed min-heap with decrease-key.
package imhdk_pkg;

  localparam int CAPACITY     = 256;
  localparam int KEY_BITS     = 32;
  localparam int VTX_BITS     = 8;
  localparam int NUM_VERTICES = 1 << VTX_BITS;
  localparam int IDX_BITS     = $clog2(CAPACITY);
  localparam int CNT_BITS     = IDX_BITS + 1;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_EXTRACT  = 2'd1;
  localparam logic [1:0] CMD_DECREASE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [VTX_BITS-1:0] vertex;
    logic [31:0]         key;
  } imhdk_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [VTX_BITS-1:0] out_vertex;
    logic [31:0]         out_key;
    logic                was_present;
    logic                heap_empty;
  } imhdk_out_t;

  typedef struct packed {
    logic [VTX_BITS-1:0] vtx;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] addr;
    entry_t              data;
  } heap_wr_t;

  typedef struct packed {
    logic                we;
    logic                clr;
    logic [VTX_BITS-1:0] vtx;
    logic [IDX_BITS-1:0] pos;
  } pos_wr_t;

endpackage

[rtl/imhdk_heap_mem.sv]
// Heap entry memory: one write port, two registered read ports.
module imhdk_heap_mem (
  input  logic                          clk,
  input  imhdk_pkg::heap_wr_t           wr,
  input  logic [imhdk_pkg::IDX_BITS-1:0] raddr_a,
  input  logic [imhdk_pkg::IDX_BITS-1:0] raddr_b,
  output imhdk_pkg::entry_t             rdata_a,
  output imhdk_pkg::entry_t             rdata_b
);
  import imhdk_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/imhdk_pos_mem.sv]
// Per-vertex position memory with presence flags.
module imhdk_pos_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  imhdk_pkg::pos_wr_t              wr,
  input  logic [imhdk_pkg::VTX_BITS-1:0]  raddr,
  output logic [imhdk_pkg::IDX_BITS-1:0]  rdata,
  output logic [imhdk_pkg::NUM_VERTICES-1:0] present
);
  import imhdk_pkg::*;

  logic [IDX_BITS-1:0]     mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] present_r;

  assign present = present_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.vtx] <= wr.pos;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr.we) begin
      present_r[wr.vtx] <= 1'b1;
    end else if (wr.clr) begin
      present_r[wr.vtx] <= 1'b0;
    end
  end

endmodule

[rtl/imhdk_seq.sv]
// Command sequencer: decodes an item and walks sift-up / sift-down over the heap memory.
module imhdk_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  imhdk_pkg::imhdk_in_t               in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output imhdk_pkg::imhdk_out_t              out_data,
  output imhdk_pkg::heap_wr_t                heap_wr,
  output logic [imhdk_pkg::IDX_BITS-1:0]     heap_raddr_a,
  output logic [imhdk_pkg::IDX_BITS-1:0]     heap_raddr_b,
  input  imhdk_pkg::entry_t                  heap_rdata_a,
  input  imhdk_pkg::entry_t                  heap_rdata_b,
  output imhdk_pkg::pos_wr_t                 pos_wr,
  output logic [imhdk_pkg::VTX_BITS-1:0]     pos_raddr,
  input  logic [imhdk_pkg::IDX_BITS-1:0]     pos_rdata,
  input  logic [imhdk_pkg::NUM_VERTICES-1:0] present
);
  import imhdk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_EX_RD, S_DC_POS, S_DC_HEAP,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_FIN, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [VTX_BITS-1:0] vtx_r, vtx_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                pres_r, pres_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [IDX_BITS-1:0] at_r, at_nxt;
  entry_t              mv_r, mv_nxt;
  imhdk_out_t          out_r, out_nxt;

  logic [CNT_BITS-1:0] lc;
  logic [CNT_BITS:0]   rc;
  logic [IDX_BITS-1:0] parent;
  logic                take_l, take_r;
  logic [KEY_BITS-1:0] best_key;

  assign lc     = {at_r, 1'b1};
  assign rc     = {1'b0, lc} + {{CNT_BITS{1'b0}}, 1'b1};
  assign parent = (at_r - {{(IDX_BITS-1){1'b0}}, 1'b1}) >> 1;

  assign take_l   = heap_rdata_a.key < mv_r.key;
  assign best_key = take_l ? heap_rdata_a.key : mv_r.key;
  assign take_r   = (rc < {1'b0, cnt_r}) && (heap_rdata_b.key < best_key);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    vtx_nxt      = vtx_r;
    key_nxt      = key_r;
    pres_nxt     = pres_r;
    cnt_nxt      = cnt_r;
    at_nxt       = at_r;
    mv_nxt       = mv_r;
    out_nxt      = out_r;
    heap_wr      = '0;
    pos_wr       = '0;
    heap_raddr_a = '0;
    heap_raddr_b = '0;
    pos_raddr    = vtx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          vtx_nxt   = in_data.vertex;
          key_nxt   = in_data.key[KEY_BITS-1:0];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        pres_nxt = present[vtx_r];
        out_nxt  = '0;
        out_nxt.was_present = present[vtx_r];
        mv_nxt   = '{vtx: vtx_r, key: key_r};
        heap_raddr_b = cnt_r[IDX_BITS-1:0] - {{(IDX_BITS-1){1'b0}}, 1'b1};
        case (cmd_r)
          CMD_INSERT: begin
            if (present[vtx_r] || cnt_r >= CNT_BITS'(CAPACITY)) begin
              out_nxt.status = ST_REFUSED;
              state_nxt = S_OUT;
            end else begin
              at_nxt    = cnt_r[IDX_BITS-1:0];
              cnt_nxt   = cnt_r + {{(CNT_BITS-1){1'b0}}, 1'b1};
              state_nxt = S_UP_RD;
            end
          end
          CMD_EXTRACT: begin
            if (cnt_r == '0) begin
              out_nxt.status = ST_EMPTY;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_EX_RD;
            end
          end
          CMD_DECREASE: state_nxt = S_DC_POS;
          default:      state_nxt = S_OUT;
        endcase
      end
      S_EX_RD: begin
        pos_wr.clr         = 1'b1;
        pos_wr.vtx         = heap_rdata_a.vtx;
        out_nxt.out_vertex = heap_rdata_a.vtx;
        out_nxt.out_key    = 32'(heap_rdata_a.key);
        cnt_nxt            = cnt_r - {{(CNT_BITS-1){1'b0}}, 1'b1};
        mv_nxt             = heap_rdata_b;
        at_nxt             = '0;
        state_nxt = (cnt_nxt == '0) ? S_OUT : S_DN_RD;
      end
      S_DC_POS: begin
        at_nxt       = pos_rdata;
        heap_raddr_a = pos_rdata;
        if (!pres_r || {1'b0, pos_rdata} >= cnt_r) begin
          out_nxt.status = ST_IGNORED;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DC_HEAP;
        end
      end
      S_DC_HEAP: begin
        if (heap_rdata_a.key <= key_r) begin
          out_nxt.status = ST_IGNORED;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        heap_raddr_a = parent;
        state_nxt = (at_r == '0) ? S_FIN : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (heap_rdata_a.key <= mv_r.key) begin
          state_nxt = S_FIN;
        end else begin
          heap_wr   = '{we: 1'b1, addr: at_r, data: heap_rdata_a};
          pos_wr.we = 1'b1;
          pos_wr.vtx = heap_rdata_a.vtx;
          pos_wr.pos = at_r;
          at_nxt    = parent;
          state_nxt = S_UP_RD;
        end
      end
      S_DN_RD: begin
        heap_raddr_a = lc[IDX_BITS-1:0];
        heap_raddr_b = rc[IDX_BITS-1:0];
        state_nxt = (lc >= cnt_r) ? S_FIN : S_DN_CMP;
      end
      S_DN_CMP: begin
        if (take_r) begin
          heap_wr    = '{we: 1'b1, addr: at_r, data: heap_rdata_b};
          pos_wr.we  = 1'b1;
          pos_wr.vtx = heap_rdata_b.vtx;
          pos_wr.pos = at_r;
          at_nxt     = rc[IDX_BITS-1:0];
          state_nxt  = S_DN_RD;
        end else if (take_l) begin
          heap_wr    = '{we: 1'b1, addr: at_r, data: heap_rdata_a};
          pos_wr.we  = 1'b1;
          pos_wr.vtx = heap_rdata_a.vtx;
          pos_wr.pos = at_r;
          at_nxt     = lc[IDX_BITS-1:0];
          state_nxt  = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        heap_wr    = '{we: 1'b1, addr: at_r, data: mv_r};
        pos_wr.we  = 1'b1;
        pos_wr.vtx = mv_r.vtx;
        pos_wr.pos = at_r;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_nxt.heap_empty = (cnt_r == '0);
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_nxt == S_OUT) begin
      out_nxt.heap_empty = (cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cmd_r  <= cmd_nxt;
    vtx_r  <= vtx_nxt;
    key_r  <= key_nxt;
    pres_r <= pres_nxt;
    at_r   <= at_nxt;
    mv_r   <= mv_nxt;
    out_r  <= out_nxt;
  end

endmodule

[rtl/indexed_min_heap_decrease_key_top.sv]
// Top level of the indexed binary min-heap with decrease-key.
//
// Input channel in_valid/in_ready/in_data carries one command item:
// insert (vertex, key), extract minimum, or decrease key (vertex, key).
// Output channel out_valid/out_ready/out_data returns one result item
// per command: status, removed vertex and key, presence, empty flag.
// One item is in flight at a time; in_ready is high only when idle.
// Insert climbs the heap by sift-up; decrease first reads the vertex's
// position and heap entry, then climbs the same way; extract reads the
// root and the last entry, then descends by sift-down; refused commands
// go straight to the result. A 256-entry heap has at most eight levels
// below the root. When out_ready is high while out_valid, the block goes
// back to idle and only then takes the next item. Each level costs a
// registered heap memory read, then the key compares and a single write
// of the displaced entry. The result is held in a register until out_ready;
// a stalled receiver keeps the block from taking the next item.
// Synchronous reset (rst_n low) empties the heap and marks every vertex
// absent; heap memory contents are not cleared and need no sweep.
`include "assert_macros.svh"

module indexed_min_heap_decrease_key_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imhdk_pkg::imhdk_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output imhdk_pkg::imhdk_out_t out_data
);
  import imhdk_pkg::*;

  heap_wr_t                heap_wr;
  logic [IDX_BITS-1:0]     heap_raddr_a, heap_raddr_b;
  entry_t                  heap_rdata_a, heap_rdata_b;
  pos_wr_t                 pos_wr;
  logic [VTX_BITS-1:0]     pos_raddr;
  logic [IDX_BITS-1:0]     pos_rdata;
  logic [NUM_VERTICES-1:0] present;

  imhdk_heap_mem u_heap (
    .clk     (clk),
    .wr      (heap_wr),
    .raddr_a (heap_raddr_a),
    .raddr_b (heap_raddr_b),
    .rdata_a (heap_rdata_a),
    .rdata_b (heap_rdata_b)
  );

  imhdk_pos_mem u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pos_wr),
    .raddr   (pos_raddr),
    .rdata   (pos_rdata),
    .present (present)
  );

  imhdk_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .heap_wr      (heap_wr),
    .heap_raddr_a (heap_raddr_a),
    .heap_raddr_b (heap_raddr_b),
    .heap_rdata_a (heap_rdata_a),
    .heap_rdata_b (heap_rdata_b),
    .pos_wr       (pos_wr),
    .pos_raddr    (pos_raddr),
    .pos_rdata    (pos_rdata),
    .present      (present)
  );

  `ASSERT_ALWAYS(a_one_in_flight, clk, rst_n, !(in_ready && out_valid))
  `ASSERT_IMPLY(a_empty_flag, clk, rst_n, out_valid && out_data.status == ST_EMPTY,
    out_data.heap_empty && out_data.out_vertex == '0 && out_data.out_key == '0)
  `ASSERT_IMPLY(a_no_write_idle, clk, rst_n, in_ready || out_valid,
    !heap_wr.we && !pos_wr.we && !pos_wr.clr)

endmodule
